// ===== src/ltok_pkg.sv =====
// Package with the shared types, constants and character codes of the line tokenizer.
`default_nettype none
package ltok_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int LENGTH_BITS = 8;
    localparam int CHAR_BITS   = 8;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int M_DATA_W    = 48;
    localparam int S_DATA_W    = 8;

    localparam logic [VALUE_BITS-1:0]  VALUE_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    localparam logic [CHAR_BITS-1:0] CH_NUL      = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_DASH     = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_PERIOD   = 8'h2E;
    localparam logic [CHAR_BITS-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE     = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_COLON    = 8'h3A;
    localparam logic [CHAR_BITS-1:0] CH_QUESTION = 8'h3F;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_Z  = 8'h7A;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_IDENT  = 2'd1,
        ST_NUMBER = 2'd2
    } scan_state_t;

    typedef enum logic [3:0] {
        TK_IDENT    = 4'd0,
        TK_NUMBER   = 4'd1,
        TK_EOL      = 4'd2,
        TK_COLON    = 4'd3,
        TK_DASH     = 4'd4,
        TK_QUESTION = 4'd5,
        TK_SLASH    = 4'd6,
        TK_PERIOD   = 4'd7,
        TK_OTHER    = 4'd8
    } token_kind_t;

    typedef struct packed {
        token_kind_t              kind;
        logic [VALUE_BITS-1:0]    value;
        logic                     ovf;
        logic [LENGTH_BITS-1:0]   length;
        logic                     last;
    } token_t;

    typedef struct packed {
        logic   pend_valid;
        token_t pend;
        logic   own_valid;
        token_t own;
    } scan_push_t;

endpackage
`default_nettype wire

// ===== src/ltok_scan.sv =====
// Input register, scanner state and per-character token classification.
`default_nettype none
module ltok_scan
    import ltok_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [CHAR_BITS-1:0] s_tdata,
    input  wire logic                 room,
    output scan_push_t                push
);

    logic                   in_valid_reg, in_valid_next;
    logic [CHAR_BITS-1:0]   char_reg;
    scan_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   ovf_reg, ovf_next;

    logic                   adv;
    logic                   is_alpha, is_digit, is_space;
    logic                   cont_ident, cont_number;
    logic [3:0]             digit;
    logic [VALUE_BITS+3:0]  acc_ext, prod;
    logic                   acc_sat;
    logic [VALUE_BITS-1:0]  acc_step;
    logic [LENGTH_BITS-1:0] len_inc;
    token_kind_t            own_kind;
    logic [LENGTH_BITS-1:0] own_len;

    assign adv      = in_valid_reg && room;
    assign s_tready = !in_valid_reg || adv;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    assign is_alpha = ((char_reg >= CH_UPPER_A) && (char_reg <= CH_UPPER_Z))
                   || ((char_reg >= CH_LOWER_A) && (char_reg <= CH_LOWER_Z));
    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_space = (char_reg == CH_SPACE) || ((char_reg >= CH_TAB) && (char_reg <= CH_CR));
    assign digit    = 4'(char_reg - CH_ZERO);

    assign cont_ident  = (state_reg == ST_IDENT) && (is_alpha || is_digit);
    assign cont_number = (state_reg == ST_NUMBER) && is_digit;

    assign acc_ext  = {4'b0000, acc_reg};
    assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_BITS{1'b0}}, digit};
    assign acc_sat  = ovf_reg || (prod > {4'b0000, VALUE_MAX});
    assign acc_step = acc_sat ? VALUE_MAX : prod[VALUE_BITS-1:0];
    assign len_inc  = (len_reg == LENGTH_MAX) ? len_reg : len_reg + 1'b1;

    always_comb begin
        unique case (char_reg)
            CH_NUL:      own_kind = TK_EOL;
            CH_COLON:    own_kind = TK_COLON;
            CH_DASH:     own_kind = TK_DASH;
            CH_QUESTION: own_kind = TK_QUESTION;
            CH_SLASH:    own_kind = TK_SLASH;
            CH_PERIOD:   own_kind = TK_PERIOD;
            default:     own_kind = TK_OTHER;
        endcase
    end

    assign own_len = ((own_kind == TK_EOL) || (own_kind == TK_OTHER))
                   ? '0 : {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    // Next-state logic of the scanner.
    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        if (adv) begin
            priority if (cont_ident) begin
                len_next = len_inc;
            end else if (cont_number) begin
                acc_next = acc_step;
                ovf_next = acc_sat;
                len_next = len_inc;
            end else if (is_alpha) begin
                state_next = ST_IDENT;
                len_next   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            end else if (is_digit) begin
                state_next = ST_NUMBER;
                acc_next   = {{(VALUE_BITS-4){1'b0}}, digit};
                ovf_next   = 1'b0;
                len_next   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    // Result logic: the pending token first, then the character's own token.
    always_comb begin
        push.own_valid  = adv && !cont_ident && !cont_number
                       && !is_alpha && !is_digit && !is_space;
        push.own.kind   = own_kind;
        push.own.value  = '0;
        push.own.ovf    = 1'b0;
        push.own.length = own_len;
        push.own.last   = 1'b1;

        push.pend_valid  = adv && ((state_reg == ST_IDENT) || (state_reg == ST_NUMBER))
                        && !cont_ident && !cont_number;
        push.pend.kind   = (state_reg == ST_NUMBER) ? TK_NUMBER : TK_IDENT;
        push.pend.value  = (state_reg == ST_NUMBER) ? acc_reg : '0;
        push.pend.ovf    = (state_reg == ST_NUMBER) ? ovf_reg : 1'b0;
        push.pend.length = len_reg;
        push.pend.last   = !push.own_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
        end
    end

    a_sat_holds_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NUMBER && ovf_reg) |-> (acc_reg == VALUE_MAX))
        else $error("Saturated number does not hold the maximum value.");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.pend_valid || push.own_valid) |-> (room && in_valid_reg))
        else $error("Token produced without queue room or input character.");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.pend_valid && push.own_valid) |-> (!push.pend.last && push.own.last))
        else $error("Wrong last marking on a two-token character.");

endmodule
`default_nettype wire

// ===== src/ltok_outq.sv =====
// Result queue that takes up to two tokens per cycle and drives the output channel.
`default_nettype none
module ltok_outq
    import ltok_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire scan_push_t          push,
    output logic                     room,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast
);

    localparam logic [QCNT_W-1:0] ROOM_LIMIT = QCNT_W'(QUEUE_DEPTH - 2);
    localparam logic [QCNT_W-1:0] FULL_COUNT = QCNT_W'(QUEUE_DEPTH);

    token_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;
    logic [QUEUE_AW-1:0]   wr_ptr_second;
    logic                  w0_valid, w1_valid, pop;
    token_t                w0;
    logic [1:0]            n_push;
    token_t                head;

    assign w0_valid = push.pend_valid || push.own_valid;
    assign w1_valid = push.pend_valid && push.own_valid;
    assign w0       = push.pend_valid ? push.pend : push.own;
    assign n_push   = {1'b0, w0_valid} + {1'b0, w1_valid};
    assign pop      = m_tvalid && m_tready;

    assign wr_ptr_second = wr_ptr_reg + 1'b1;
    assign wr_ptr_next   = wr_ptr_reg + QUEUE_AW'(n_push);
    assign rd_ptr_next   = rd_ptr_reg + QUEUE_AW'(pop);
    assign count_next    = count_reg + QCNT_W'(n_push) - QCNT_W'(pop);

    assign room     = (count_reg <= ROOM_LIMIT);
    assign m_tvalid = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];
    assign m_tdata  = {4'b0000, head.length, head.ovf, head.value, head.kind};
    assign m_tlast  = head.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (w0_valid) begin
            entry_reg[wr_ptr_reg] <= w0;
        end
        if (w1_valid) begin
            entry_reg[wr_ptr_second] <= push.own;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("Result queue count exceeds its depth.");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !w0_valid) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("Result queue count did not drop after a lone transaction.");

endmodule
`default_nettype wire

// ===== src/line_tokenizer.sv =====
// Top level of the line tokenizer: character stream in, token stream out.
//
// One byte of a command line enters per transaction on the s_ channel. Letters
// start identifiers, digits start decimal numbers, and a zero byte, five
// punctuation marks and any other non-blank byte give tokens of their own.
// A byte that ends an identifier or number can cause two tokens: the pending
// one first, then its own; m_tlast marks the final token caused by a byte.
// Whitespace bytes cause no token of their own.
// A byte is registered in the input register when accepted and classified
// there; its tokens go into the result queue once it has room for two, and
// m_ is driven from the head of the queue.
// A new byte can be accepted every cycle while the queue has room; the result
// queue of four entries drains one token per cycle while m_tready is high, so
// bytes that cause two tokens hold back s_tready once the queue has filled.
// When the receiver stalls, the queue fills and s_tready drops while fewer
// than two entries are free; no token is lost.
// Reset clears the scanner to idle with no pending token and empties the queue.
`default_nettype none
module line_tokenizer
    import ltok_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // char_in[7:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // token_kind[3:0], number_value[34:4], value_overflow[35], token_length[43:36]
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast    // last_of_run
);

    scan_push_t push;
    logic       room;

    ltok_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata[CHAR_BITS-1:0]),
        .room     (room),
        .push     (push)
    );

    ltok_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== tb/line_tokenizer_test.sv =====
// Testbench for the line tokenizer: random byte streams checked against a token predictor.
`timescale 1ns / 100ps

module line_tokenizer_test;
    import ltok_pkg::*;

    localparam int ITEM_COUNT = 1200;

    class token_scoreboard;
        scan_state_t            state;
        logic [VALUE_BITS-1:0]  number_acc;
        logic [LENGTH_BITS-1:0] length_cnt;
        bit                     overflow_seen;
        token_t                 expected_tokens[$];
        int unsigned            errors;

        function new();
            state         = ST_IDLE;
            number_acc    = '0;
            length_cnt    = '0;
            overflow_seen = 1'b0;
            errors        = 0;
        endfunction

        function void add_token(token_kind_t kind, logic [VALUE_BITS-1:0] value, logic ovf,
                                logic [LENGTH_BITS-1:0] length);
            token_t t;
            t.kind   = kind;
            t.value  = value;
            t.ovf    = ovf;
            t.length = length;
            t.last   = 1'b0;
            expected_tokens.push_back(t);
        endfunction

        function void add_digit(logic [3:0] d);
            if (overflow_seen || number_acc > (VALUE_MAX - d) / 10) begin
                number_acc    = VALUE_MAX;
                overflow_seen = 1'b1;
            end else begin
                number_acc = VALUE_BITS'(number_acc * 10 + d);
            end
        endfunction

        function void bump_length();
            if (length_cnt != LENGTH_MAX)
                length_cnt++;
        endfunction

        // Predicts the tokens caused by one accepted byte.
        function void note_char(logic [7:0] c);
            bit letter;
            bit digit;
            int n_before;
            letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
            digit  = c >= CH_ZERO && c <= CH_NINE;
            n_before = expected_tokens.size();
            if (state == ST_IDENT && (letter || digit)) begin
                bump_length();
                return;
            end
            if (state == ST_NUMBER && digit) begin
                add_digit(4'(c - CH_ZERO));
                bump_length();
                return;
            end
            if (state == ST_IDENT)
                add_token(TK_IDENT, '0, 1'b0, length_cnt);
            else if (state == ST_NUMBER)
                add_token(TK_NUMBER, number_acc, overflow_seen, length_cnt);
            state = ST_IDLE;
            if (letter) begin
                state      = ST_IDENT;
                length_cnt = 1;
            end else if (digit) begin
                state         = ST_NUMBER;
                number_acc    = '0;
                overflow_seen = 1'b0;
                add_digit(4'(c - CH_ZERO));
                length_cnt    = 1;
            end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                case (c)
                    CH_NUL:      add_token(TK_EOL, '0, 1'b0, 0);
                    CH_COLON:    add_token(TK_COLON, '0, 1'b0, 1);
                    CH_DASH:     add_token(TK_DASH, '0, 1'b0, 1);
                    CH_QUESTION: add_token(TK_QUESTION, '0, 1'b0, 1);
                    CH_SLASH:    add_token(TK_SLASH, '0, 1'b0, 1);
                    CH_PERIOD:   add_token(TK_PERIOD, '0, 1'b0, 1);
                    default:     add_token(TK_OTHER, '0, 1'b0, 0);
                endcase
            end
            if (expected_tokens.size() > n_before)
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        endfunction

        function void check_token(logic [M_DATA_W-1:0] data, logic last);
            token_t want;
            if (expected_tokens.size() == 0) begin
                $error("Token received with none expected: data %h, last %b", data, last);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            if (data[3:0] !== want.kind) begin
                $error("token_kind mismatch: expected %0d, actual %0d", want.kind, data[3:0]);
                errors++;
            end
            if (data[4 +: VALUE_BITS] !== want.value) begin
                $error("number_value mismatch: expected %0d, actual %0d", want.value,
                       data[4 +: VALUE_BITS]);
                errors++;
            end
            if (data[4 + VALUE_BITS] !== want.ovf) begin
                $error("value_overflow mismatch: expected %0d, actual %0d", want.ovf,
                       data[4 + VALUE_BITS]);
                errors++;
            end
            if (data[5 + VALUE_BITS +: LENGTH_BITS] !== want.length) begin
                $error("token_length mismatch: expected %0d, actual %0d", want.length,
                       data[5 + VALUE_BITS +: LENGTH_BITS]);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run mismatch: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int unsigned     send_idle_pct = 11;
    int unsigned     recv_idle_pct = 70;
    logic [7:0]      line_chars[$];
    token_scoreboard sb = new();

    line_tokenizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_token(m_tdata, m_tlast);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [7:0] pick_blank();
        int unsigned pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CH_SPACE : 8'(CH_TAB + pick);
    endfunction

    // Appends an identifier or a run of digits of the given length.
    function automatic void add_token_text(bit digits_only, int unsigned len);
        int unsigned r;
        for (int unsigned i = 0; i < len; i++) begin
            if (digits_only) begin
                line_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end else begin
                r = (i == 0) ? $urandom_range(10, 61) : $urandom_range(0, 61);
                if (r < 10)
                    line_chars.push_back(8'(CH_ZERO + r));
                else if (r < 36)
                    line_chars.push_back(8'(CH_UPPER_A + r - 10));
                else
                    line_chars.push_back(8'(CH_LOWER_A + r - 36));
            end
        end
    endfunction

    function automatic void add_number_value(longint unsigned v);
        string digits;
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++)
            line_chars.push_back(8'(digits[i]));
    endfunction

    task automatic send_char(logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_char(c);
    endtask

    initial begin : stimulus
        logic [7:0]  punct[6];
        int unsigned pick;
        int unsigned wait_cycles;
        bit          long_ident_done;
        bit          long_number_done;
        punct = '{CH_COLON, CH_DASH, CH_QUESTION, CH_SLASH, CH_PERIOD, CH_NUL};
        long_ident_done  = 1'b0;
        long_number_done = 1'b0;

        // Directed start: every kind, both ends of the letter, digit and blank ranges, a space,
        // a line feed, repeated end of line and high bytes.
        line_chars = {CH_UPPER_A, CH_LOWER_Z, CH_NINE, CH_COLON, CH_ZERO, CH_DASH, CH_QUESTION,
                      CH_SLASH, CH_PERIOD, CH_UPPER_Z, CH_LOWER_A, CH_TAB, CH_CR, CH_SPACE,
                      CH_NUL, CH_NUL, CH_NINE, 8'hFF, 8'h80, CH_ZERO, CH_NUL, 8'h0A};

        while (line_chars.size() < ITEM_COUNT) begin
            if (!long_ident_done) begin
                add_token_text(1'b0, $urandom_range(256, 270));
                line_chars.push_back(pick_blank());
                long_ident_done = 1'b1;
            end else if (!long_number_done && line_chars.size() >= ITEM_COUNT / 2) begin
                add_token_text(1'b1, $urandom_range(256, 270));
                line_chars.push_back(punct[$urandom_range(0, 5)]);
                long_number_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
                add_token_text(1'b0, $urandom_range(1, 12));
            else if (pick < 52)
                add_token_text(1'b1, $urandom_range(1, 12));
            else if (pick < 60)
                add_number_value(64'd2147483600 + $urandom_range(0, 100));
            else if (pick < 78)
                line_chars.push_back(punct[$urandom_range(0, 5)]);
            else if (pick < 86)
                repeat ($urandom_range(1, 3)) line_chars.push_back(pick_blank());
            else
                line_chars.push_back(8'($urandom_range(0, 255)));
            if (pick < 60 && $urandom_range(0, 1))
                line_chars.push_back(pick_blank());
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < line_chars.size(); i++) begin
            if (i < line_chars.size() / 3) begin
                send_idle_pct = 11;
                recv_idle_pct = 70;
            end else if (i < 2 * line_chars.size() / 3) begin
                send_idle_pct = 70;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_char(line_chars[i]);
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (sb.expected_tokens.size() != 0 && wait_cycles < 10000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (20) @(posedge aclk);
        if (sb.expected_tokens.size() != 0) begin
            $error("%0d expected tokens never arrived", sb.expected_tokens.size());
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
